FILE: hdl/sorted_array_priority_queue_defines.svh
// Assertion macros used by the queue checker.
`ifndef SORTED_ARRAY_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_ARRAY_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SAPQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define SAPQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

FILE: hdl/sapq_pkg.sv
// Types and constants of the sorted-array priority queue.
`default_nettype none
package sapq_pkg;

    localparam int DEPTH = 64;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CAP_W = 7;
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [31:0] prio;
        logic [15:0]        job;
        logic [3:0]         evt;
    } entry_t;

    // Broadcast from the controller to every cell
    typedef struct packed {
        logic   push;
        logic   pop;
        entry_t entry;
    } cell_ctl_t;

endpackage
`default_nettype wire

FILE: hdl/sapq_cell.sv
// One slot of the sorted chain: holds an entry and trades with its neighbors.
`default_nettype none
module sapq_cell
    import sapq_pkg::*;
(
    input  wire logic      clk,
    input  wire cell_ctl_t ctl,
    input  wire logic      occupied,
    input  wire logic      is_tail,
    input  wire entry_t    left_entry,
    input  wire logic      left_greater,
    input  wire entry_t    right_entry,
    output entry_t         entry,
    output logic           greater
);

    entry_t entry_reg;
    entry_t entry_next;

    // Ordering is strict so equal priorities stay behind older entries
    assign greater = occupied && ($signed(entry_reg.prio) > $signed(ctl.entry.prio));
    assign entry   = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.push)
        begin
            if (greater || is_tail)
            begin
                entry_next = left_greater ? left_entry : ctl.entry;
            end
        end
        else if (ctl.pop)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule
`default_nettype wire

FILE: hdl/sorted_array_priority_queue.sv
// Top level of the sorted-array priority queue: control, count and cell chain.
//
// Sorted-array priority queue. Holds up to DEPTH entries (priority, job id,
// event code) in a row of cells kept in ascending priority order; equal
// priorities leave in arrival order. A command is taken at any clock edge
// with start high and busy low; busy never rises, so one push or pop is
// taken every cycle. Each command gives exactly one result, on the result
// ports for a single cycle with done high, in the cycle after the command
// is taken. The receiver cannot stall: it must capture the result in that
// cycle. A push compares the new priority against every cell at once and
// shifts the larger entries one place toward the tail; a pop shifts every
// cell one place toward the head. That no command stalls rests on that
// parallel compare and the per-cell 32-bit comparator. A push is rejected
// with status 1 once the count reaches capacity_limit (capped at DEPTH);
// a pop on an empty queue returns status 2. Popped fields read zero on
// every result that is not a successful pop. count reports the entries
// held after the transaction. capacity_limit is written through the
// configuration channel, which is always ready; write it only while idle.
`default_nettype none
module sorted_array_priority_queue
    import sapq_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               cmd,
    input  wire logic signed [31:0] in_priority,
    input  wire logic [15:0]        in_job,
    input  wire logic [3:0]         in_event,
    output logic                    done,
    output logic [1:0]              status,
    output logic signed [31:0]      out_priority,
    output logic [15:0]             out_job,
    output logic [3:0]              out_event,
    output logic [6:0]              count,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [6:0]         cfg_data
);

    logic [CAP_W-1:0] capacity_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             done_reg;
    status_t          status_reg;
    status_t          status_next;
    entry_t           pop_reg;
    entry_t           pop_next;

    logic      accept;
    logic      full;
    logic      empty;
    cell_ctl_t ctl;

    entry_t cell_entry   [DEPTH];
    logic   cell_greater [DEPTH];

    // Busy is never raised: each transaction is completed by the edge that takes it
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // Full against both the register and the physical depth
    assign full  = (CMP_W'(count_reg) >= CMP_W'(capacity_reg))
                || (CMP_W'(count_reg) >= CMP_W'(DEPTH));
    assign empty = (count_reg == '0);

    assign ctl.push        = accept && (cmd == CMD_PUSH) && !full;
    assign ctl.pop         = accept && (cmd == CMD_POP) && !empty;
    assign ctl.entry.prio  = in_priority;
    assign ctl.entry.job   = in_job;
    assign ctl.entry.evt   = in_event;

    // Build the chain: cell 0 is the head
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
        entry_t left_entry;
        logic   left_greater;
        entry_t right_entry;

        if (i == 0)
        begin : g_head
            assign left_entry   = ctl.entry;
            assign left_greater = 1'b0;
        end
        else
        begin : g_body
            assign left_entry   = cell_entry[i-1];
            assign left_greater = cell_greater[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            // Last slot holds on a pop; it is beyond the count afterwards
            assign right_entry = cell_entry[i];
        end
        else
        begin : g_mid
            assign right_entry = cell_entry[i+1];
        end

        sapq_cell u_cell (
            .clk          (clk),
            .ctl          (ctl),
            .occupied     (IDX < count_reg),
            .is_tail      (IDX == count_reg),
            .left_entry   (left_entry),
            .left_greater (left_greater),
            .right_entry  (right_entry),
            .entry        (cell_entry[i]),
            .greater      (cell_greater[i])
        );
    end

    // Result and count for the transaction taken this cycle
    always_comb
    begin
        count_next  = count_reg;
        status_next = ST_DONE;
        pop_next    = '0;
        if (cmd == CMD_PUSH)
        begin
            if (full)
            begin
                status_next = ST_FULL;
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
        else
        begin
            if (empty)
            begin
                status_next = ST_EMPTY;
            end
            else
            begin
                pop_next   = cell_entry[0];
                count_next = count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
            count_reg    <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                capacity_reg <= cfg_data;
            end
            if (accept)
            begin
                count_reg <= count_next;
            end
            done_reg <= accept;
        end
    end

    // Result payload: hold between transactions
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            pop_reg    <= pop_next;
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign out_priority = pop_reg.prio;
    assign out_job      = pop_reg.job;
    assign out_event    = pop_reg.evt;
    assign count        = CAP_W'(count_reg);

endmodule
`default_nettype wire

FILE: hdl/sapq_checker.sv
// Port-level checks on the priority queue and their binding to the top level.
`default_nettype none
`include "sorted_array_priority_queue_defines.svh"
module sapq_checker
    import sapq_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic               cmd,
    input wire logic               done,
    input wire logic [1:0]         status,
    input wire logic signed [31:0] out_priority,
    input wire logic [6:0]         count
);

    `SAPQ_ASSERT_NEXT(a_result_follows, start && !busy, done)
    `SAPQ_ASSERT_NEXT(a_no_spurious_result, !(start && !busy), !done)
    `SAPQ_ASSERT_NOW(a_empty_pop, done && (status == ST_EMPTY),
        (count == 7'd0) && (out_priority == 32'sd0) && ($past(cmd) == CMD_POP))
    `SAPQ_ASSERT_NOW(a_full_push, done && (status == ST_FULL),
        ($past(cmd) == CMD_PUSH) && (count == $past(count)))
    `SAPQ_ASSERT_NOW(a_push_grows, done && (status == ST_DONE) && ($past(cmd) == CMD_PUSH),
        count == 7'($past(count) + 7'd1))

endmodule

bind sorted_array_priority_queue sapq_checker u_sapq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .done         (done),
    .status       (status),
    .out_priority (out_priority),
    .count        (count)
);
`default_nettype wire
